// File: rtl/core/fpg_pkg.sv
// fpg_pkg: shared constants, opcode and state-machine types, and the
// command/status structs between the gravity-grid controller and datapath.
// No dependencies.
package fpg_pkg;

  // Grid geometry
  localparam int GRID_W = 320;
  localparam int GRID_H = 240;
  localparam int COL_AW = $clog2(GRID_W);
  localparam int ROW_AW = $clog2(GRID_H);

  // Payload widths of the channels
  localparam int OP_W     = 2;
  localparam int POS_X_W  = 9;
  localparam int POS_Y_W  = 8;
  localparam int RADIUS_W = 6;

  // Signed coordinate width (covers the largest grid plus blob offsets)
  localparam int CRD_W = 14;
  // Signed blob offset width (-31..30)
  localparam int OFS_W = 7;
  // Squared-distance width
  localparam int SQ_W  = 12;

  typedef enum logic [OP_W-1:0] {
    OP_BLOB = 2'd0,
    OP_GRAV = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [12:0] {
    S_CLEAR   = 13'b0000000000001,
    S_IDLE    = 13'b0000000000010,
    S_G_START = 13'b0000000000100,
    S_G_BELOW = 13'b0000000001000,
    S_G_STEP  = 13'b0000000010000,
    S_G_TOP   = 13'b0000000100000,
    S_R_RD    = 13'b0000001000000,
    S_B_INIT  = 13'b0000010000000,
    S_B_ROW   = 13'b0000100000000,
    S_B_WAIT  = 13'b0001000000000,
    S_B_COL   = 13'b0010000000000,
    S_B_WR    = 13'b0100000000000,
    S_FINISH  = 13'b1000000000000
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;     // latch request payload
    logic clr_wr;      // clearing pass: zero one row
    logic grav_first;  // read bottom row, reset row counter
    logic grav_below;  // load bottom row, read the row above
    logic grav_step;   // settle one row pair
    logic grav_top;    // write back row 0
    logic cell_rd;     // read row of the addressed cell
    logic blob_init;   // dy to start of blob
    logic blob_row;    // read the blob row
    logic blob_load;   // load row buffer, dx to start
    logic blob_col;    // toggle one cell, dx advance
    logic blob_wr;     // write back the blob row
    logic dy_inc;      // next blob row
    logic res_load;    // load the result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    op_t  op;
    logic half_zero;
    logic row_ok;
    logic dx_last;
    logic dy_last;
    logic row_zero;
    logic row_one;
  } status_t;

endpackage

// File: rtl/core/fpg_if.sv
// Request and response channel interfaces of the particle grid.
// Depends on fpg_pkg for field widths.

interface fpg_req_if import fpg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [POS_X_W-1:0]  pos_x;
  logic [POS_Y_W-1:0]  pos_y;
  logic [RADIUS_W-1:0] radius;

  modport source(output valid, op, pos_x, pos_y, radius, input ready);
  modport sink(input valid, op, pos_x, pos_y, radius, output ready);
endinterface

interface fpg_rsp_if import fpg_pkg::*; ();
  logic valid;
  logic ready;
  logic moved;
  logic cell_res;

  modport source(output valid, moved, cell_res, input ready);
  modport sink(input valid, moved, cell_res, output ready);
endinterface

// File: rtl/core/fpg_ctrl.sv
// fpg_ctrl: sequencer for clearing, gravity, blob toggle and cell read.
// Depends on fpg_pkg (state_t, cmd_t, status_t).
module fpg_ctrl import fpg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  logic    rsp_ready,
  output logic    rsp_valid,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   out_valid;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = out_valid;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.row_zero) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_B_INIT; // refined once the op is latched
        end
      end
      S_B_INIT: begin
        // first cycle after capture: dispatch on the latched op
        unique case (sts.op)
          OP_BLOB: begin
            cmd.blob_init = 1'b1;
            state_next    = sts.half_zero ? S_FINISH : S_B_ROW;
          end
          OP_GRAV: begin
            cmd.grav_first = 1'b1;
            state_next     = S_G_BELOW;
          end
          OP_READ: begin
            cmd.cell_rd = 1'b1;
            state_next  = S_R_RD;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_G_START: begin
        cmd.grav_first = 1'b1;
        state_next     = S_G_BELOW;
      end
      S_G_BELOW: begin
        cmd.grav_below = 1'b1;
        state_next     = S_G_STEP;
      end
      S_G_STEP: begin
        cmd.grav_step = 1'b1;
        if (sts.row_one) state_next = S_G_TOP;
      end
      S_G_TOP: begin
        cmd.grav_top = 1'b1;
        state_next   = S_FINISH;
      end
      S_R_RD: begin
        state_next = S_FINISH;
      end
      S_B_ROW: begin
        if (sts.row_ok) begin
          cmd.blob_row = 1'b1;
          state_next   = S_B_WAIT;
        end else if (sts.dy_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.dy_inc = 1'b1;
        end
      end
      S_B_WAIT: begin
        cmd.blob_load = 1'b1;
        state_next    = S_B_COL;
      end
      S_B_COL: begin
        cmd.blob_col = 1'b1;
        if (sts.dx_last) state_next = S_B_WR;
      end
      S_B_WR: begin
        cmd.blob_wr = 1'b1;
        if (sts.dy_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.dy_inc = 1'b1;
          state_next = S_B_ROW;
        end
      end
      S_FINISH: begin
        if (!out_valid || rsp_ready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (cmd.res_load) out_valid <= 1'b1;
    else if (rsp_ready)    out_valid <= 1'b0;
  end

endmodule

// File: rtl/core/fpg_datapath.sv
// fpg_datapath: row-wide grid memory, row buffer, blob geometry, row and
// offset counters, and the result register. Depends on fpg_pkg.
module fpg_datapath import fpg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [OP_W-1:0]     op,
  input  logic [POS_X_W-1:0]  pos_x,
  input  logic [POS_Y_W-1:0]  pos_y,
  input  logic [RADIUS_W-1:0] radius,
  input  cmd_t                cmd,
  output status_t             sts,
  output logic                moved,
  output logic                cell_res
);

  // Grid memory, one row per word
  logic [GRID_W-1:0] mem [GRID_H];
  logic [GRID_W-1:0] rdata;
  logic              we, re;
  logic [ROW_AW-1:0] wa, ra;
  logic [GRID_W-1:0] wd;

  // Latched request
  op_t                 op_q;
  logic [POS_X_W-1:0]  px_q;
  logic [POS_Y_W-1:0]  py_q;
  logic [RADIUS_W-1:0] r_q;

  // Working registers
  logic [GRID_W-1:0]       line;
  logic [ROW_AW-1:0]       row;
  logic signed [OFS_W-1:0] dx, dy;
  logic                    moved_acc;

  // Blob geometry
  logic [RADIUS_W-2:0]         half;
  logic signed [OFS_W-1:0]     half_s, half_m1;
  logic [2*RADIUS_W-1:0]       r_sq;
  logic signed [2*OFS_W-1:0]   dx_sq, dy_sq;
  logic [SQ_W-1:0]             sq_sum;
  logic                        in_disc;
  logic signed [CRD_W-1:0]     row_c, col_c, pxe, pye;
  logic                        row_ok, col_ok, cell_ok;
  logic [ROW_AW-1:0]           row_idx, py_idx;
  logic [COL_AW-1:0]           col_idx, px_idx;

  // Gravity row pair
  logic [GRID_W-1:0] move_mask, new_below, new_above;

  assign half    = r_q[RADIUS_W-1:1];
  assign half_s  = $signed(OFS_W'(half));
  assign half_m1 = half_s - $signed(OFS_W'(1));
  assign r_sq    = (2*RADIUS_W)'(r_q) * (2*RADIUS_W)'(r_q);
  assign dx_sq   = (2*OFS_W)'(dx) * (2*OFS_W)'(dx);
  assign dy_sq   = (2*OFS_W)'(dy) * (2*OFS_W)'(dy);
  assign sq_sum  = SQ_W'($unsigned(dx_sq)) + SQ_W'($unsigned(dy_sq));
  assign in_disc = sq_sum < SQ_W'(r_sq[2*RADIUS_W-1:2]);

  assign pxe   = $signed(CRD_W'(px_q));
  assign pye   = $signed(CRD_W'(py_q));
  assign row_c = pye + CRD_W'(dy);
  assign col_c = pxe + CRD_W'(dx);

  assign row_ok  = (row_c >= 0) && (row_c < $signed(CRD_W'(GRID_H)));
  assign col_ok  = (col_c >= 0) && (col_c < $signed(CRD_W'(GRID_W)));
  assign cell_ok = (pxe < $signed(CRD_W'(GRID_W))) && (pye < $signed(CRD_W'(GRID_H)));

  assign row_idx = row_c[ROW_AW-1:0];
  assign col_idx = col_c[COL_AW-1:0];
  assign py_idx  = pye[ROW_AW-1:0];
  assign px_idx  = pxe[COL_AW-1:0];

  // A particle drops where the lower cell is empty
  assign move_mask = ~line & rdata;
  assign new_below = line | move_mask;
  assign new_above = rdata & ~move_mask;

  // Status to controller
  assign sts.op        = op_q;
  assign sts.half_zero = (half == '0);
  assign sts.row_ok    = row_ok;
  assign sts.dx_last   = (dx == half_m1);
  assign sts.dy_last   = (dy == half_m1);
  assign sts.row_zero  = (row == '0);
  assign sts.row_one   = (row == ROW_AW'(1));

  // Memory port selection
  always_comb begin
    we = cmd.clr_wr | cmd.grav_step | cmd.grav_top | cmd.blob_wr;
    if (cmd.grav_top)     wa = '0;
    else if (cmd.blob_wr) wa = row_idx;
    else                  wa = row;
    if (cmd.clr_wr)         wd = '0;
    else if (cmd.grav_step) wd = new_below;
    else                    wd = line;

    re = cmd.grav_first | cmd.grav_below | cmd.blob_row
       | (cmd.grav_step && (row > ROW_AW'(1)))
       | (cmd.cell_rd && cell_ok);
    if (cmd.grav_first)      ra = ROW_AW'(GRID_H - 1);
    else if (cmd.grav_below) ra = row - ROW_AW'(1);
    else if (cmd.grav_step)  ra = row - ROW_AW'(2);
    else if (cmd.cell_rd)    ra = py_idx;
    else                     ra = row_idx;
  end

  // Grid memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rdata <= mem[ra];
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= op_t'(op);
      px_q <= pos_x;
      py_q <= pos_y;
      r_q  <= radius;
    end
  end

  // Row counter: clearing pass and gravity sweep
  always_ff @(posedge clk) begin
    if (rst)                            row <= ROW_AW'(GRID_H - 1);
    else if (cmd.grav_first)            row <= ROW_AW'(GRID_H - 1);
    else if (cmd.clr_wr || cmd.grav_step) row <= row - ROW_AW'(1);
  end

  // Row buffer
  always_ff @(posedge clk) begin
    if (cmd.grav_below || cmd.blob_load) line <= rdata;
    else if (cmd.grav_step)              line <= new_above;
    else if (cmd.blob_col && in_disc && col_ok) line[col_idx] <= ~line[col_idx];
  end

  // Blob offsets
  always_ff @(posedge clk) begin
    if (cmd.blob_init)    dy <= -half_s;
    else if (cmd.dy_inc)  dy <= dy + $signed(OFS_W'(1));
    if (cmd.blob_load)    dx <= -half_s;
    else if (cmd.blob_col) dx <= dx + $signed(OFS_W'(1));
  end

  // Any-move flag of a gravity step
  always_ff @(posedge clk) begin
    if (cmd.grav_first)     moved_acc <= 1'b0;
    else if (cmd.grav_step) moved_acc <= moved_acc | (|move_mask);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      moved    <= (op_q == OP_GRAV) & moved_acc;
      cell_res <= (op_q == OP_READ) & cell_ok & rdata[px_idx];
    end
  end

endmodule

// File: rtl/core/falling_particle_grid.sv
// falling_particle_grid: top level of the one-bit falling-particle grid.
// Depends on fpg_pkg, fpg_if, fpg_ctrl and fpg_datapath.
//
//  channel  dir  payload                          transaction
//  req      in   op, pos_x, pos_y, radius         valid && ready
//  rsp      out  moved, cell_res                  valid && ready
//
// A gravity step settles one row pair per cycle on the row-wide memory
// port; a blob toggles one cell per cycle. After reset a clearing pass
// writes zero to every row; req.ready stays low until it ends. A new
// request is taken while the last result still waits on rsp; a finished
// item holds until the result register frees.
module falling_particle_grid import fpg_pkg::*; (
  input logic      clk,
  input logic      rst,
  fpg_req_if.sink  req,
  fpg_rsp_if.source rsp
);

  cmd_t    cmd;
  status_t sts;

  fpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpg_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .op       (req.op),
    .pos_x    (req.pos_x),
    .pos_y    (req.pos_y),
    .radius   (req.radius),
    .cmd      (cmd),
    .sts      (sts),
    .moved    (rsp.moved),
    .cell_res (rsp.cell_res)
  );

endmodule

// File: rtl/core/fpg_checker.sv
// fpg_checker: port-level assertions for falling_particle_grid, with bind.
// Depends on falling_particle_grid ports only.
module fpg_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic moved,
  input logic cell_res
);

  logic       req_fire, rsp_fire;
  logic [1:0] pending;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // Items taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) pending <= 2'd0;
    else     pending <= pending + {1'b0, req_fire} - {1'b0, rsp_fire};
  end

  // Reset empties the result register and starts the clearing pass
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid && !req_ready)
    else $error("response or ready active right after reset");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(moved) && $stable(cell_res))
    else $error("stalled response changed");

  // Only one result field can be set for any op
  a_one_field: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(moved && cell_res))
    else $error("moved and cell_res both set");

  // Every response answers an accepted request
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    rsp_fire |-> pending != 2'd0)
    else $error("response without a pending request");

  // At most one item in work plus one waiting result
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many outstanding requests");

endmodule

bind falling_particle_grid fpg_checker u_fpg_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .moved     (rsp.moved),
  .cell_res  (rsp.cell_res)
);

// File: test/fpg_grid_checker.sv
// fpg_grid_checker: watches the request and response channels of the particle
// grid, keeps its own copy of the grid and compares every response in order.
// Depends on fpg_pkg and the fpg_req_if / fpg_rsp_if interfaces.
module fpg_grid_checker import fpg_pkg::*; (
  input  logic clk,
  input  logic rst,
  fpg_req_if   req,
  fpg_rsp_if   rsp,
  output int   fail_count,
  output int   rsp_waiting,
  output int   moves_seen,
  output int   set_cells_read
);

  typedef struct packed {
    op_t  op;
    logic moved;
    logic cell_res;
  } grid_rsp_t;

  // One packed row per grid row; bit index is the column
  logic [GRID_W-1:0] plane [GRID_H];
  grid_rsp_t         rsp_due_q [$];
  grid_rsp_t         want;
  int                fails;
  int                rsp_count;
  int                moves;
  int                set_reads;

  // Toggle the disc of cells around (cx, cy); cells off the grid are skipped
  function automatic void flip_disc(input int cx, input int cy, input int r);
    int half;
    int lim;
    int col;
    int row;
    half = r / 2;
    lim  = (r * r) / 4;
    for (int dx = -half; dx < half; dx++) begin
      for (int dy = -half; dy < half; dy++) begin
        col = cx + dx;
        row = cy + dy;
        if (dx * dx + dy * dy < lim && col >= 0 && col < GRID_W && row >= 0 && row < GRID_H)
          plane[row][col] = ~plane[row][col];
      end
    end
  endfunction

  // One gravity sweep, bottom row pair first, so nothing falls more than a row
  function automatic logic settle_step();
    logic [GRID_W-1:0] falling;
    logic              any;
    any = 1'b0;
    for (int row = GRID_H - 1; row > 0; row--) begin
      falling      = plane[row-1] & ~plane[row];
      plane[row]   = plane[row] | falling;
      plane[row-1] = plane[row-1] & ~falling;
      any          = any | (|falling);
    end
    return any;
  endfunction

  // Update the grid copy for one request and return the response it must give
  function automatic grid_rsp_t apply_request(input op_t op, input int x, input int y,
                                              input int r);
    grid_rsp_t res;
    res    = '0;
    res.op = op;
    case (op)
      OP_BLOB: flip_disc(x, y, r);
      OP_GRAV: res.moved = settle_step();
      OP_READ: if (x < GRID_W && y < GRID_H) res.cell_res = plane[y][x];
      default: ;
    endcase
    return res;
  endfunction

  task automatic log_fail(input string msg);
    if (fails < 10)
      $display("[%0t] grid check: %s", $time, msg);
    fails++;
  endtask

  // Responses are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    if (rst) begin
      for (int row = 0; row < GRID_H; row++)
        plane[row] = '0;
      rsp_due_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (rsp_due_q.size() == 0) begin
          log_fail($sformatf("response %0d with nothing outstanding (moved %b, cell %b)",
                             rsp_count, rsp.moved, rsp.cell_res));
        end else begin
          want = rsp_due_q.pop_front();
          if (rsp.moved !== want.moved)
            log_fail($sformatf("response %0d (%s): moved expected %b, got %b",
                               rsp_count, want.op.name(), want.moved, rsp.moved));
          if (rsp.cell_res !== want.cell_res)
            log_fail($sformatf("response %0d (%s): cell_res expected %b, got %b",
                               rsp_count, want.op.name(), want.cell_res, rsp.cell_res));
          if (want.moved)
            moves++;
          if (want.cell_res)
            set_reads++;
        end
        rsp_count++;
      end
      if (req.valid && req.ready)
        rsp_due_q.push_back(apply_request(op_t'(req.op), int'(req.pos_x), int'(req.pos_y),
                                          int'(req.radius)));
    end
    fail_count     <= fails;
    rsp_waiting    <= rsp_due_q.size();
    moves_seen     <= moves;
    set_cells_read <= set_reads;
  end

endmodule

// File: test/falling_particle_grid_test.sv
// falling_particle_grid_test: drives blob, gravity, read and unused-op requests into the
// particle grid with random idling and reports the verdict from fpg_grid_checker.
// Depends on fpg_pkg, fpg_if, falling_particle_grid and fpg_grid_checker.
module falling_particle_grid_test;
  import fpg_pkg::*;

  localparam int LONG_HOLD    = 300;
  // Generous: every item at the largest blob plus both-side stalls, several times over
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fpg_req_if req_ch ();
  fpg_rsp_if rsp_ch ();

  int fail_count;
  int rsp_waiting;
  int moves_seen;
  int set_cells_read;

  bit idle_en;
  int holds_asked;
  int holds_done;
  int cycles;
  int items_sent;
  int blobs_sent;
  int steps_sent;
  int reads_sent;
  int others_sent;

  // Last blob placed and how many steps it has had to fall
  int spot_x;
  int spot_y;
  int spot_r;
  int falls;

  falling_particle_grid dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  fpg_grid_checker grid_check (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .fail_count     (fail_count),
    .rsp_waiting    (rsp_waiting),
    .moves_seen     (moves_seen),
    .set_cells_read (set_cells_read)
  );

  always #2 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, rsp_waiting);
      $display("falling_particle_grid_test failed");
      $finish;
    end
  end

  // Response side: long hold on request, else random stall bursts while idling is on
  initial begin
    int n;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        rsp_ch.ready <= 1'b0;
        for (int k = 1; k < LONG_HOLD; k++)
          @(negedge clk);
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        rsp_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic int fit(input int v, input int hi);
    return v < 0 ? 0 : (v > hi ? hi : v);
  endfunction

  // Offer one transaction from a falling edge; returns at the edge after acceptance
  task automatic send_item(input op_t op, input int x, input int y, input int r);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.op     <= op;
    req_ch.pos_x  <= x[POS_X_W-1:0];
    req_ch.pos_y  <= y[POS_Y_W-1:0];
    req_ch.radius <= r[RADIUS_W-1:0];
    @(posedge clk);
    while (!req_ch.ready)
      @(posedge clk);
    @(negedge clk);
    items_sent++;
    case (op)
      OP_BLOB: blobs_sent++;
      OP_GRAV: steps_sent++;
      OP_READ: reads_sent++;
      default: others_sent++;
    endcase
  endtask

  // Read a cell around the last blob, allowing for how far it may have fallen
  task automatic read_near_spot();
    int h;
    int x;
    int y;
    h = spot_r / 2 + 2;
    x = fit(spot_x + int'($urandom_range(0, 2 * h)) - h, 511);
    y = fit(spot_y + int'($urandom_range(0, 2 * h + falls)) - h, 255);
    send_item(OP_READ, x, y, int'($urandom_range(0, 63)));
  endtask

  // Blob, a few gravity steps, reads around it, and some noise
  task automatic run_episode();
    int pick;
    int n;
    pick = $urandom_range(0, 9);
    if (pick < 7)
      spot_r = $urandom_range(0, 15);
    else if (pick < 9)
      spot_r = $urandom_range(16, 40);
    else
      spot_r = $urandom_range(41, 63);
    if ($urandom_range(0, 6) == 0) begin
      spot_x = $urandom_range(0, 511);
      spot_y = $urandom_range(0, 255);
    end else begin
      spot_x = $urandom_range(0, GRID_W - 1);
      spot_y = $urandom_range(0, GRID_H - 1);
    end
    send_item(OP_BLOB, spot_x, spot_y, spot_r);
    falls = 0;
    n = $urandom_range(0, 4);
    repeat (n) begin
      send_item(OP_GRAV, int'($urandom_range(0, 511)), int'($urandom_range(0, 255)),
                int'($urandom_range(0, 63)));
      falls++;
    end
    n = $urandom_range(1, 4);
    repeat (n) read_near_spot();
    case ($urandom_range(0, 5))
      0: send_item(OP_NONE, int'($urandom_range(0, 511)), int'($urandom_range(0, 255)),
                   int'($urandom_range(0, 63)));
      1: send_item(OP_READ, int'($urandom_range(0, 511)), int'($urandom_range(0, 255)),
                   int'($urandom_range(0, 63)));
      2: send_item(OP_READ, int'($urandom_range(0, GRID_W - 1)), GRID_H - 1, 0);
      default: ;
    endcase
  endtask

  // Stimulus and verdict
  initial begin
    req_ch.valid  = 1'b0;
    req_ch.op     = OP_NONE;
    req_ch.pos_x  = '0;
    req_ch.pos_y  = '0;
    req_ch.radius = '0;
    idle_en       = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: corners and off-grid reads on the empty grid, unused op, gravity step
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_READ, GRID_W - 1, GRID_H - 1, 63);
    send_item(OP_READ, 511, 255, 0);
    send_item(OP_NONE, 511, 255, 63);
    send_item(OP_GRAV, 0, 0, 0);
    // Radius 0 and 1 give an empty disc
    send_item(OP_BLOB, 100, 100, 0);
    send_item(OP_BLOB, 100, 100, 1);
    // Single cell on the bottom row cannot fall
    send_item(OP_BLOB, 10, GRID_H - 1, 2);
    send_item(OP_READ, 10, GRID_H - 1, 0);
    send_item(OP_GRAV, 0, 0, 0);
    send_item(OP_BLOB, 10, GRID_H - 1, 2);
    // Largest blobs clipped at the corners, one undone by its repeat
    send_item(OP_BLOB, 0, 0, 63);
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_BLOB, 0, 0, 63);
    send_item(OP_BLOB, GRID_W - 1, GRID_H - 1, 63);
    send_item(OP_READ, GRID_W - 1, GRID_H - 1, 0);
    send_item(OP_GRAV, 0, 0, 0);
    // Blob entirely off the grid
    send_item(OP_BLOB, 511, 255, 63);
    // Mid-grid blob that has room to fall
    send_item(OP_BLOB, 160, 120, 40);
    send_item(OP_GRAV, 0, 0, 0);
    send_item(OP_READ, 160, 139, 0);
    send_item(OP_READ, 160, 100, 0);
    send_item(OP_READ, 256, 128, 32);
    send_item(OP_NONE, 0, 0, 0);
    send_item(OP_GRAV, 0, 0, 0);
    spot_x = 160;
    spot_y = 120;
    spot_r = 40;
    falls  = 2;

    // Random episodes with idling, one long response hold in the middle
    idle_en = 1'b1;
    while (items_sent < 75) begin
      if (items_sent >= 45 && holds_asked == 0) begin
        holds_asked = 1;
        repeat (8) read_near_spot();
      end
      run_episode();
    end

    // Closing stretch without idling
    idle_en = 1'b0;
    while (items_sent < 100)
      run_episode();
    req_ch.valid <= 1'b0;

    while (rsp_waiting != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d transactions: %0d blobs, %0d gravity steps, %0d reads, %0d unused ops",
             items_sent, blobs_sent, steps_sent, reads_sent, others_sent);
    $display("steps that moved particles: %0d, reads of set cells: %0d, failures: %0d",
             moves_seen, set_cells_read, fail_count);
    if (fail_count == 0 && rsp_waiting == 0)
      $display("falling_particle_grid_test passed");
    else
      $display("falling_particle_grid_test failed");
    $finish;
  end

endmodule
